@@ rtl/core/assert_macros.svh @@
// assertion macros shared by the classifier rtl
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define VTDC_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// expression must never be true outside reset
`define VTDC_NEVER(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) else $error(msg);

`else

`define VTDC_ASSERT(lbl, clk, rstn, prop, msg)
`define VTDC_NEVER(lbl, clk, rstn, expr, msg)

`endif

`endif

@@ rtl/core/vtdc_pkg.sv @@
// shared types, codes and match helpers for the vlan tag / dhcp classifier
// no dependencies; used by the parser, output stage and top level
package vtdc_pkg;

    localparam logic [15:0] TPID_8021Q  = 16'h8100;
    localparam logic [15:0] TPID_8021AD = 16'h88A8;
    localparam logic [15:0] TPID_LEGACY = 16'h9100;
    localparam logic [15:0] ETYPE_IPV4  = 16'h0800;
    localparam logic [15:0] ETYPE_IPV6  = 16'h86DD;

    localparam logic [7:0]  IP_PROTO_UDP    = 8'd17;
    localparam logic [15:0] DHCPV4_SRV_PORT = 16'd67;
    localparam logic [15:0] DHCPV6_SRV_PORT = 16'd547;

    localparam logic [11:0] VID_MASK = 12'hFFF;

    localparam int DATA_W  = 8;
    localparam int TDATA_W = 40;

    typedef enum logic [1:0] {
        PK_NONE  = 2'd0,
        PK_IPV4  = 2'd1,
        PK_IPV6  = 2'd2,
        PK_OTHER = 2'd3
    } payload_kind_t;

    typedef enum logic [1:0] {
        DHCP_NONE = 2'd0,
        DHCP_V4   = 2'd1,
        DHCP_V6   = 2'd2
    } dhcp_kind_t;

    typedef struct packed {
        dhcp_kind_t  dhcp_kind;
        logic [3:0]  inner_pcp_dei;
        logic [3:0]  outer_pcp_dei;
        logic [11:0] inner_vid;
        logic [11:0] outer_vid;
        logic [1:0]  tag_count;
    } result_t;

    function automatic logic tpid_match(input logic [15:0] t);
        return (t == TPID_8021Q) || (t == TPID_8021AD) || (t == TPID_LEGACY);
    endfunction

    function automatic payload_kind_t kind_of(input logic [15:0] t);
        payload_kind_t k;
        k = PK_OTHER;
        if (t == ETYPE_IPV4) k = PK_IPV4;
        else if (t == ETYPE_IPV6) k = PK_IPV6;
        return k;
    endfunction

endpackage

@@ rtl/core/vtdc_parser.sv @@
// per-byte frame parser: tag capture, ethertype decode, udp port checks
// depends on vtdc_pkg; result is combinational on the final byte
module vtdc_parser
    import vtdc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              byte_accept,
    input  logic [DATA_W-1:0] data_byte,
    input  logic              end_of_frame,
    output logic              res_valid,
    output result_t           res
);

    logic [7:0]    pos_reg, pos_next;
    logic [15:0]   type_shift_reg, type_shift_next;
    logic [1:0]    tags_reg, tags_next, tags_final;
    logic [15:0]   outer_tci_reg, outer_tci_next;
    logic [15:0]   inner_tci_reg, inner_tci_next;
    payload_kind_t pk_reg, pk_next;
    logic [6:0]    ihl_reg, ihl_next;
    logic          udp_reg, udp_next;
    logic          hit_reg, hit_next;

    logic [7:0] slot;
    logic [7:0] l2len;
    logic [7:0] off;
    logic [8:0] frame_len;
    logic [8:0] l2len_final;
    logic [8:0] avail;
    dhcp_kind_t kind;

    always_comb begin
        type_shift_next = {type_shift_reg[7:0], data_byte};
        tags_next       = tags_reg;
        pk_next         = pk_reg;
        outer_tci_next  = outer_tci_reg;
        inner_tci_next  = inner_tci_reg;
        ihl_next        = ihl_reg;
        udp_next        = udp_reg;
        hit_next        = hit_reg;

        slot = 8'd13 + {4'd0, tags_reg, 2'b00};

        // ethertype low byte: another tag or the payload type
        if (pk_reg == PK_NONE && pos_reg == slot) begin
            if (tags_reg < 2'd2 && tpid_match(type_shift_next)) begin
                tags_next = tags_reg + 2'd1;
            end else begin
                pk_next = kind_of(type_shift_next);
            end
        end

        if (tags_next == 2'd1) begin
            if (pos_reg == 8'd14) outer_tci_next = {data_byte, 8'd0};
            else if (pos_reg == 8'd15) outer_tci_next = {outer_tci_reg[15:8], data_byte};
        end else if (tags_next == 2'd2) begin
            if (pos_reg == 8'd18) inner_tci_next = {data_byte, 8'd0};
            else if (pos_reg == 8'd19) inner_tci_next = {inner_tci_reg[15:8], data_byte};
        end

        l2len = 8'd14 + {4'd0, tags_next, 2'b00};
        off   = pos_reg - l2len;
        if ((pk_next == PK_IPV4 || pk_next == PK_IPV6) && pos_reg >= l2len) begin
            if (pk_next == PK_IPV4) begin
                if (off == 8'd0) ihl_next = {1'b0, data_byte[3:0], 2'b00};
                if (off == 8'd9) udp_next = (data_byte == IP_PROTO_UDP);
                if (off == ({1'b0, ihl_reg} + 8'd3))
                    hit_next = (type_shift_next == DHCPV4_SRV_PORT);
            end else begin
                if (off == 8'd6) udp_next = (data_byte == IP_PROTO_UDP);
                if (off == 8'd43) hit_next = (type_shift_next == DHCPV6_SRV_PORT);
            end
        end

        pos_next = (pos_reg == 8'hFF) ? pos_reg : pos_reg + 8'd1;

        // frame cut after an ethertype high byte: low byte reads as zero
        tags_final = tags_next;
        if (pk_next == PK_NONE && tags_next < 2'd2 &&
            ({1'b0, pos_reg} + 9'd1) == {1'b0, slot} &&
            tpid_match({data_byte, 8'd0})) begin
            tags_final = tags_next + 2'd1;
        end

        frame_len   = {1'b0, pos_reg} + 9'd1;
        l2len_final = 9'd14 + {5'd0, tags_final, 2'b00};
        avail       = frame_len - l2len_final;
        kind        = DHCP_NONE;
        if (frame_len >= l2len_final) begin
            if (pk_next == PK_IPV4) begin
                if (avail >= 9'd28 && udp_next && hit_next &&
                    avail >= ({2'd0, ihl_next} + 9'd8)) begin
                    kind = DHCP_V4;
                end
            end else if (pk_next == PK_IPV6) begin
                if (avail >= 9'd48 && udp_next && hit_next) kind = DHCP_V6;
            end
        end

        res.tag_count     = tags_final;
        res.outer_vid     = outer_tci_next[11:0] & VID_MASK;
        res.outer_pcp_dei = outer_tci_next[15:12];
        res.inner_vid     = (tags_final == 2'd2) ? (inner_tci_next[11:0] & VID_MASK) : 12'd0;
        res.inner_pcp_dei = (tags_final == 2'd2) ? inner_tci_next[15:12] : 4'd0;
        res.dhcp_kind     = kind;
        res_valid         = byte_accept && end_of_frame;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg        <= '0;
            type_shift_reg <= '0;
            tags_reg       <= '0;
            outer_tci_reg  <= '0;
            inner_tci_reg  <= '0;
            pk_reg         <= PK_NONE;
            ihl_reg        <= '0;
            udp_reg        <= 1'b0;
            hit_reg        <= 1'b0;
        end else if (byte_accept) begin
            if (end_of_frame) begin
                pos_reg        <= '0;
                type_shift_reg <= '0;
                tags_reg       <= '0;
                outer_tci_reg  <= '0;
                inner_tci_reg  <= '0;
                pk_reg         <= PK_NONE;
                ihl_reg        <= '0;
                udp_reg        <= 1'b0;
                hit_reg        <= 1'b0;
            end else begin
                pos_reg        <= pos_next;
                type_shift_reg <= type_shift_next;
                tags_reg       <= tags_next;
                outer_tci_reg  <= outer_tci_next;
                inner_tci_reg  <= inner_tci_next;
                pk_reg         <= pk_next;
                ihl_reg        <= ihl_next;
                udp_reg        <= udp_next;
                hit_reg        <= hit_next;
            end
        end
    end

endmodule

@@ rtl/core/vtdc_out_reg.sv @@
// result register between the parser and the result stream
// depends on vtdc_pkg; packs the result fields into tdata
module vtdc_out_reg
    import vtdc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               res_valid,
    input  result_t            res,
    output logic               up_ready,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata
);

    logic    valid_reg;
    result_t res_reg;

    assign up_ready = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = {4'd0, res_reg.dhcp_kind, res_reg.inner_pcp_dei, res_reg.outer_pcp_dei,
                       res_reg.inner_vid, res_reg.outer_vid, res_reg.tag_count};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (res_valid) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            res_reg <= res;
        end
    end

endmodule

@@ rtl/core/vlan_tag_dhcp_classifier_core.sv @@
// Frame bytes enter one per cycle on the s_ stream, with tlast on the final byte, unless
// s_tready stalls them; the block finds up to two vlan tags and flags dhcpv4/dhcpv6
// server-bound requests. Every byte updates small frame-state registers. One request
// comes out per frame, in the cycle after its last byte, from a result register; s_tready
// drops only while that register is full and m_tready is low.
// depends on vtdc_pkg, vtdc_parser, vtdc_out_reg and assert_macros.svh
`include "assert_macros.svh"

module vlan_tag_dhcp_classifier_core
    import vtdc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [DATA_W-1:0]  s_tdata,   // data_byte[7:0]
    input  logic               s_tlast,
    output logic               m_tvalid,
    input  logic               m_tready,
    // tag_count[1:0], outer_vid[13:2], inner_vid[25:14], outer_pcp_dei[29:26],
    // inner_pcp_dei[33:30], dhcp_kind[35:34], zero[39:36]
    output logic [TDATA_W-1:0] m_tdata
);

    logic    byte_accept;
    logic    res_valid;
    result_t res;

    assign byte_accept = s_tvalid && s_tready;

    vtdc_parser u_parser (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .byte_accept  (byte_accept),
        .data_byte    (s_tdata),
        .end_of_frame (s_tlast),
        .res_valid    (res_valid),
        .res          (res)
    );

    vtdc_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res       (res),
        .up_ready  (s_tready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    `VTDC_ASSERT(a_eof_gives_request, aclk, aresetn,
                 byte_accept && s_tlast |=> m_tvalid,
                 "no request after final byte")
    `VTDC_NEVER(a_kind_code, aclk, aresetn,
                m_tvalid && m_tdata[35:34] == 2'd3,
                "bad dhcp kind")
    `VTDC_NEVER(a_tag_count, aclk, aresetn,
                m_tvalid && m_tdata[1:0] == 2'd3,
                "tag count above two")
    `VTDC_ASSERT(a_inner_zero, aclk, aresetn,
                 m_tvalid && m_tdata[1:0] != 2'd2 |->
                 m_tdata[33:30] == 4'd0 && m_tdata[25:14] == 12'd0,
                 "inner tag set with fewer than two tags")

endmodule
